// ----- design/lru_pkg.sv -----
// Package: types, constants and codes of the LRU write-back block cache
`default_nettype none
package lru_pkg;
  localparam int ENTRIES  = 16;
  localparam int LBA_BITS = 48;
  localparam int SLOT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W    = $clog2(ENTRIES + 1);

  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_WBACK = 2'd1;
  localparam logic [1:0] OP_FETCH = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [47:0] block_lba;
  } lru_in_t;

  typedef struct packed {
    logic [1:0]  device_op;
    logic [47:0] op_lba;
    logic [3:0]  slot;
    logic        hit;
    logic        last;
  } lru_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOOK, ST_EVICT, ST_FETCH, ST_FLUSH
  } lru_state_t;

  // per-cycle command from controller to every cell
  typedef struct packed {
    logic                load;     // fill the chosen cell
    logic [SLOT_W-1:0]   load_idx;
    logic                promote;  // promote cell hit_idx
    logic [SLOT_W-1:0]   hit_idx;
    logic [SLOT_W-1:0]   hit_rank;
    logic                set_dirty;
    logic                evict;    // drop cell with rank == evict_rank
    logic [SLOT_W-1:0]   evict_rank;
    logic                clean;    // clear dirty of cell clean_idx
    logic [SLOT_W-1:0]   clean_idx;
    logic                age_all;
    logic                wr_dirty;
  } lru_ctl_t;
endpackage
`default_nettype wire

// ----- design/lru_cell.sv -----
// One cache entry: tag, valid, dirty and recency rank, with its own compare
`default_nettype none
module lru_cell
  import lru_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [SLOT_W-1:0]   my_idx,
  input  wire lru_ctl_t            ctl,
  input  wire logic [LBA_BITS-1:0] lba,
  output logic                     valid,
  output logic                     dirty,
  output logic [SLOT_W-1:0]        rank,
  output logic [LBA_BITS-1:0]      tag,
  output logic                     match
);
  logic [LBA_BITS-1:0] tag_r;
  logic valid_r, dirty_r;
  logic [SLOT_W-1:0] rank_r;

  assign valid = valid_r;
  assign dirty = dirty_r;
  assign rank  = rank_r;
  assign tag   = tag_r;
  assign match = valid_r && (tag_r == lba);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      if (ctl.promote && valid_r) begin
        if (my_idx == ctl.hit_idx) begin
          rank_r <= '0;
          if (ctl.set_dirty) dirty_r <= 1'b1;
        end else if (rank_r < ctl.hit_rank) begin
          rank_r <= rank_r + 1'b1;
        end
      end
      if (ctl.evict && valid_r && rank_r == ctl.evict_rank) begin
        valid_r <= 1'b0;
        dirty_r <= 1'b0;
        rank_r  <= '0;
      end
      if (ctl.clean && my_idx == ctl.clean_idx) dirty_r <= 1'b0;
      if (ctl.age_all && valid_r) rank_r <= rank_r + 1'b1;
      if (ctl.load && my_idx == ctl.load_idx) begin
        valid_r <= 1'b1;
        dirty_r <= ctl.wr_dirty;
        rank_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && my_idx == ctl.load_idx) tag_r <= lba;
  end
endmodule
`default_nettype wire

// ----- design/lru_write_back_block_cache.sv -----
// Top level: controller and row of entry cells of the LRU write-back cache
//
// Usage: pulse start with in_word while busy is low. The block then walks
// the entries and presents at most one result word per cycle on out_word,
// marked by out_valid; out_word.last flags the final word of the command.
// busy stays high until the final word has been shown. The receiver cannot
// stall. A hit returns its word in the cycle after start is taken; a miss
// goes through the lookup, evict (per evicted entry) and fetch states. A
// flush walks one rank per cycle from rank 0 up to the last dirty entry;
// with no dirty entry it walks every occupied rank, then shows a lone last
// word. A new command is accepted at the edge after busy falls. Eviction
// and flush cost is set by the walk over recency ranks, one rank per cycle.
// cfg_we writes the capacity (entries_in_use); the user must do so only
// while idle, which the block does not enforce. Reset empties the cache and
// sets the capacity to 16; no clearing pass is needed. A rank compare at
// every cell picks victims and flushes.
`default_nettype none
module lru_write_back_block_cache
  import lru_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire lru_in_t  in_word,
  output logic          out_valid,
  output lru_out_t      out_word,
  input  wire logic     cfg_we,
  input  wire logic [4:0] cfg_wdata
);
  lru_state_t state_r, state_nxt;
  logic [1:0] cmd_r;
  logic [LBA_BITS-1:0] lba_r;
  logic [4:0] cap_r;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [CNT_W-1:0] walk_r, walk_nxt;
  logic emitted_r, emitted_nxt;
  lru_ctl_t ctl;

  logic [ENTRIES-1:0] v, d, m;
  logic [SLOT_W-1:0] rk [ENTRIES];
  logic [LBA_BITS-1:0] tg [ENTRIES];

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      lru_cell u_cell (
        .clk(clk), .rst_n(rst_n), .my_idx(SLOT_W'(g)), .ctl(ctl), .lba(lba_r),
        .valid(v[g]), .dirty(d[g]), .rank(rk[g]), .tag(tg[g]), .match(m[g])
      );
    end
  endgenerate

  // hit, rank-select and free-slot encoders
  logic hit_any, sel_any;
  logic [SLOT_W-1:0] hit_idx, sel_idx, free_idx, hit_rank;
  logic [SLOT_W-1:0] walk_rank;
  assign walk_rank = (state_r == ST_EVICT) ? SLOT_W'(occ_r - 1'b1) : walk_r[SLOT_W-1:0];
  always_comb begin
    hit_any = 1'b0; hit_idx = '0; hit_rank = '0;
    sel_any = 1'b0; sel_idx = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (m[i]) begin hit_any = 1'b1; hit_idx = SLOT_W'(i); hit_rank = rk[i]; end
      if (v[i] && rk[i] == walk_rank) begin sel_any = 1'b1; sel_idx = SLOT_W'(i); end
      if (!v[i]) free_idx = SLOT_W'(i);
    end
  end

  // any dirty entry at a rank beyond the one now walked
  logic pending_after;
  always_comb begin
    pending_after = 1'b0;
    for (int i = 0; i < ENTRIES; i++)
      if (v[i] && d[i] && CNT_W'(rk[i]) > walk_r && CNT_W'(rk[i]) < occ_r)
        pending_after = 1'b1;
  end

  logic [CNT_W-1:0] cap_eff;
  always_comb begin
    if (cap_r == 5'd0) cap_eff = CNT_W'(1);
    else if (32'(cap_r) > ENTRIES) cap_eff = CNT_W'(ENTRIES);
    else cap_eff = CNT_W'(cap_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = (in_word.command == CMD_FLUSH) ? ST_FLUSH : ST_LOOK;
      ST_LOOK: begin
        if (cmd_r == CMD_UNUSED || hit_any) state_nxt = ST_IDLE;
        else if (occ_r >= cap_eff && occ_r != '0) state_nxt = ST_EVICT;
        else state_nxt = ST_FETCH;
      end
      ST_EVICT: if (occ_r - 1'b1 < cap_eff || occ_r == CNT_W'(1)) state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = ST_IDLE;
      ST_FLUSH: begin
        if (walk_r >= occ_r || (sel_any && d[sel_idx] && !pending_after))
          state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.hit_idx = hit_idx; ctl.hit_rank = hit_rank;
    ctl.set_dirty = (cmd_r == CMD_WRITE);
    ctl.wr_dirty = (cmd_r == CMD_WRITE);
    ctl.evict_rank = SLOT_W'(occ_r - 1'b1);
    ctl.clean_idx = sel_idx;
    ctl.load_idx = free_idx;
    out_valid = 1'b0; out_word = '0;
    occ_nxt = occ_r; walk_nxt = walk_r; emitted_nxt = emitted_r;
    unique case (state_r)
      ST_IDLE: begin walk_nxt = '0; emitted_nxt = 1'b0; end
      ST_LOOK: begin
        if (cmd_r == CMD_UNUSED) begin
          out_valid = 1'b1; out_word.last = 1'b1;
        end else if (hit_any) begin
          ctl.promote = 1'b1;
          out_valid = 1'b1;
          out_word = '{OP_NONE, lba_r, 4'(hit_idx), 1'b1, 1'b1};
        end
      end
      ST_EVICT: begin
        ctl.evict = 1'b1;
        occ_nxt = occ_r - 1'b1;
        if (sel_any && d[sel_idx]) begin
          out_valid = 1'b1;
          out_word = '{OP_WBACK, tg[sel_idx], 4'(sel_idx), 1'b0, 1'b0};
        end
      end
      ST_FETCH: begin
        ctl.age_all = 1'b1; ctl.load = 1'b1;
        occ_nxt = occ_r + 1'b1;
        out_valid = 1'b1;
        out_word = '{OP_FETCH, lba_r, 4'(free_idx), 1'b0, 1'b1};
      end
      ST_FLUSH: begin
        // one rank per cycle; the final cycle closes with a last word
        if (walk_r < occ_r) begin
          walk_nxt = walk_r + 1'b1;
          if (sel_any && d[sel_idx]) begin
            ctl.clean = 1'b1;
            emitted_nxt = 1'b1;
            out_valid = 1'b1;
            out_word = '{OP_WBACK, tg[sel_idx], 4'(sel_idx), 1'b0, 1'b0};
            if (!pending_after) out_word.last = 1'b1;
          end
        end else if (!emitted_r) begin
          out_valid = 1'b1; out_word.last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; occ_r <= '0; walk_r <= '0; emitted_r <= 1'b0;
      cap_r <= 5'd16;
    end else begin
      state_r <= state_nxt; occ_r <= occ_nxt; walk_r <= walk_nxt;
      emitted_r <= emitted_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r <= in_word.command;
      lba_r <= in_word.block_lba[LBA_BITS-1:0];
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(ENTRIES)) else $error("occupancy overflow");
  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(m)) else $error("tag matches in two entries");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.last |=> !busy) else $error("busy after last word");
  a_start_word: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("command not taken");
endmodule
`default_nettype wire
